// ===== rtl/pse_pkg.sv =====
// Shared constants, codes and types of the postfix stack evaluator.
package pse_pkg;

	localparam int DATA_W     = 32;
	localparam int DEPTH_W    = 7;
	localparam int STATUS_W   = 2;
	localparam int FN_W       = 2;
	localparam int ARG_W      = 3;
	localparam int CMD_W      = 4;
	localparam int CFG_ADDR_W = 4;
	localparam int REG_IDX_W  = 2;

	localparam int DEF_STACK_DEPTH = 64;
	localparam int DIV_STEPS       = DATA_W;
	localparam int STEP_W          = $clog2(DIV_STEPS);

	localparam logic [CMD_W-1:0] CMD_LIT0 = 4'd0;
	localparam logic [CMD_W-1:0] CMD_LIT1 = 4'd1;
	localparam logic [CMD_W-1:0] CMD_A    = 4'd2;
	localparam logic [CMD_W-1:0] CMD_B    = 4'd3;
	localparam logic [CMD_W-1:0] CMD_C    = 4'd4;
	localparam logic [CMD_W-1:0] CMD_ADD  = 4'd5;
	localparam logic [CMD_W-1:0] CMD_SUB  = 4'd6;
	localparam logic [CMD_W-1:0] CMD_MUL  = 4'd7;
	localparam logic [CMD_W-1:0] CMD_DIV  = 4'd8;

	localparam logic [FN_W-1:0] FN_LIT = 2'd0;
	localparam logic [FN_W-1:0] FN_LOD = 2'd1;
	localparam logic [FN_W-1:0] FN_OPR = 2'd2;

	localparam logic [ARG_W-1:0] ARG_NONE = 3'd0;
	localparam logic [ARG_W-1:0] ARG_ZERO = 3'd0;
	localparam logic [ARG_W-1:0] ARG_ONE  = 3'd1;
	localparam logic [ARG_W-1:0] SLOT_A   = 3'd3;
	localparam logic [ARG_W-1:0] SLOT_B   = 3'd4;
	localparam logic [ARG_W-1:0] SLOT_C   = 3'd5;
	localparam logic [ARG_W-1:0] ARG_ADD  = 3'd2;
	localparam logic [ARG_W-1:0] ARG_SUB  = 3'd3;
	localparam logic [ARG_W-1:0] ARG_MUL  = 3'd4;
	localparam logic [ARG_W-1:0] ARG_DIV  = 3'd5;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_UNDER = 2'd1;
	localparam logic [STATUS_W-1:0] ST_OVER  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_DIV0  = 2'd3;

	localparam logic [REG_IDX_W-1:0] REG_A = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_B = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_C = 2'd2;

	localparam logic [DATA_W-1:0] RST_VALUE_A = 32'd5;
	localparam logic [DATA_W-1:0] RST_VALUE_B = 32'd3;
	localparam logic [DATA_W-1:0] RST_VALUE_C = 32'd2;
	localparam logic [DATA_W-1:0] EMPTY_TOP   = '1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_EXEC,
		S_DIV,
		S_DIV_FIX,
		S_WRITE,
		S_DONE
	} pse_state_t;

endpackage

// ===== rtl/pse_if.sv =====
// Request and result channel interfaces of the postfix stack evaluator.
interface pse_cmd_if import pse_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CMD_W-1:0] command;
	logic             start_new;

	modport source (output valid, output command, output start_new, input ready);
	modport sink (input valid, input command, input start_new, output ready);
endinterface

interface pse_res_if import pse_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [DATA_W-1:0]   top_value;
	logic        [DEPTH_W-1:0]  depth;
	logic        [STATUS_W-1:0] status;
	logic        [FN_W-1:0]     pcode_function;
	logic        [ARG_W-1:0]    pcode_argument;

	modport source (output valid, output top_value, output depth, output status,
		output pcode_function, output pcode_argument, input ready);
	modport sink (input valid, input top_value, input depth, input status,
		input pcode_function, input pcode_argument, output ready);
endinterface

// ===== rtl/postfix_stack_evaluator_unit.sv =====
// Postfix stack evaluator: token sequencer, operand stack and shared arithmetic unit.
//
// Usage:
//   cmd carries one postfix token per request (command, start_new); res returns one
//   result per request: top of stack, depth, status and the p-code mapping.
//   The user writes value_a, value_b and value_c over the APB port (0x0, 0x4, 0x8)
//   only while the block is idle, which it does not enforce; pready is always high
//   and reads return the registers. From the accepting edge to res.valid, an operand
//   or unknown token passes DECODE and DONE; add/sub/mul pass DECODE, EXEC, WRITE
//   and DONE; a divide adds the S_DIV loop and S_DIV_FIX after EXEC (divide by zero
//   goes from EXEC to WRITE). The 32-step radix-2 divide loop on the shared adder
//   sets the worst case; cmd.ready is high only while the sequencer is idle, so one
//   token is in work at a time; the next can be taken the cycle after the result loads.
// The stack is a single-port-write, single-port-read memory; the top entry is
//   also held in a register, so a pop needs one memory read.
// Reset clears the stack depth, the sequencer and the result valid flag and loads
//   the register reset values; no clearing pass over the memory is needed.
// When res.ready is low the result holds and the sequencer waits with the next
//   result until the result register is taken.
module postfix_stack_evaluator_unit import pse_pkg::*; #(
	parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0]     pwdata,
	output logic [DATA_W-1:0]     prdata,
	output logic                  pready,
	pse_cmd_if.sink               cmd,
	pse_res_if.source             res
);

	localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	pse_state_t state_q, state_d;

	logic [DATA_W-1:0] value_a_q, value_b_q, value_c_q;
	logic [REG_IDX_W-1:0] reg_idx;

	logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
	logic              mem_we, mem_re;
	logic [ADDR_W-1:0] mem_waddr, mem_raddr;
	logic [DATA_W-1:0] mem_wdata, rd_q;

	logic [CNT_W-1:0]    count_q;
	logic [DATA_W-1:0]   top_q, y_q, res_q, rem_q, quo_q, dvs_q;
	logic [CMD_W-1:0]    cmd_q;
	logic [STATUS_W-1:0] status_q;
	logic [FN_W-1:0]     func_q;
	logic [ARG_W-1:0]    arg_q;
	logic                under_q, div0_q, neg_q;
	logic [STEP_W-1:0]   step_q;

	logic                out_valid_q;
	logic [DATA_W-1:0]   out_top_q;
	logic [DEPTH_W-1:0]  out_depth_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [FN_W-1:0]     out_func_q;
	logic [ARG_W-1:0]    out_arg_q;

	logic              cnt_ge1, cnt_ge2, cnt_full, is_operand, is_operator;
	logic              in_fire, out_load;
	logic [DATA_W-1:0] push_val, x_val, x_abs, y_abs, prod;
	logic [DATA_W:0]   alu_a, alu_b;
	logic              alu_sub, div_ge;
	logic [DATA_W+1:0] alu_sum;

	// Configuration port
	assign pready  = 1'b1;
	assign reg_idx = paddr[CFG_ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_a_q <= RST_VALUE_A;
			value_b_q <= RST_VALUE_B;
			value_c_q <= RST_VALUE_C;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx)
				REG_A:   value_a_q <= pwdata;
				REG_B:   value_b_q <= pwdata;
				REG_C:   value_c_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_A:   prdata = value_a_q;
			REG_B:   prdata = value_b_q;
			REG_C:   prdata = value_c_q;
			default: prdata = '0;
		endcase
	end

	// Token decode
	assign cnt_ge1     = (count_q >= CNT_W'(1));
	assign cnt_ge2     = (count_q >= CNT_W'(2));
	assign cnt_full    = (count_q >= CNT_W'(STACK_DEPTH));
	assign is_operand  = (cmd_q <= CMD_C);
	assign is_operator = (cmd_q >= CMD_ADD) && (cmd_q <= CMD_DIV);

	always_comb begin
		unique case (cmd_q)
			CMD_LIT0: push_val = '0;
			CMD_LIT1: push_val = DATA_W'(1);
			CMD_A:    push_val = value_a_q;
			CMD_B:    push_val = value_b_q;
			CMD_C:    push_val = value_c_q;
			default:  push_val = '0;
		endcase
	end

	// Shared arithmetic unit
	assign x_val = cnt_ge2 ? rd_q : EMPTY_TOP;
	assign x_abs = x_val[DATA_W-1] ? (~x_val + DATA_W'(1)) : x_val;
	assign y_abs = y_q[DATA_W-1] ? (~y_q + DATA_W'(1)) : y_q;
	assign prod  = x_val * y_q;

	always_comb begin
		alu_a   = {1'b0, x_val};
		alu_b   = {1'b0, y_q};
		alu_sub = (cmd_q == CMD_SUB);
		unique case (state_q)
			S_DIV: begin
				alu_a   = {rem_q, quo_q[DATA_W-1]};
				alu_b   = {1'b0, dvs_q};
				alu_sub = 1'b1;
			end
			S_DIV_FIX: begin
				alu_a   = '0;
				alu_b   = {1'b0, quo_q};
				alu_sub = 1'b1;
			end
			default: ;
		endcase
	end

	assign alu_sum = {1'b0, alu_a} + ({1'b0, alu_b} ^ {(DATA_W + 2){alu_sub}})
		+ (DATA_W + 2)'(alu_sub);
	assign div_ge  = !alu_sum[DATA_W+1];

	// Sequencer
	assign in_fire  = cmd.valid && cmd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd.ready = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = ADDR_W'(count_q);
		mem_raddr = ADDR_W'(count_q - CNT_W'(2));
		mem_wdata = push_val;
		out_load  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				cmd.ready = 1'b1;
				if (cmd.valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (is_operand) begin
					mem_we  = !cnt_full;
					state_d = S_DONE;
				end else if (is_operator) begin
					mem_re  = cnt_ge2;
					state_d = S_EXEC;
				end else begin
					state_d = S_DONE;
				end
			end
			S_EXEC: begin
				if (cmd_q == CMD_DIV && y_q != '0) begin
					state_d = S_DIV;
				end else begin
					state_d = S_WRITE;
				end
			end
			S_DIV: begin
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					state_d = S_DIV_FIX;
				end
			end
			S_DIV_FIX: begin
				state_d = S_WRITE;
			end
			S_WRITE: begin
				mem_we    = 1'b1;
				mem_waddr = cnt_ge2 ? ADDR_W'(count_q - CNT_W'(2)) : '0;
				mem_wdata = res_q;
				state_d   = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || res.ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Stack memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			stack_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= stack_mem[mem_raddr];
		end
	end

	// Stack depth and top
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			priority if (in_fire && cmd.start_new) begin
				count_q <= '0;
			end else if (state_q == S_DECODE && is_operand && !cnt_full) begin
				count_q <= CNT_W'(count_q + CNT_W'(1));
			end else if (state_q == S_WRITE) begin
				count_q <= cnt_ge2 ? CNT_W'(count_q - CNT_W'(1)) : CNT_W'(1);
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					cmd_q <= cmd.command;
				end
			end
			S_DECODE: begin
				under_q <= !cnt_ge2;
				div0_q  <= 1'b0;
				y_q     <= cnt_ge1 ? top_q : EMPTY_TOP;
				if (is_operand) begin
					if (!cnt_full) begin
						top_q    <= push_val;
						status_q <= ST_OK;
					end else begin
						status_q <= ST_OVER;
					end
				end else begin
					status_q <= ST_OK;
				end
				unique case (cmd_q)
					CMD_LIT0: begin func_q <= FN_LIT; arg_q <= ARG_ZERO; end
					CMD_LIT1: begin func_q <= FN_LIT; arg_q <= ARG_ONE;  end
					CMD_A:    begin func_q <= FN_LOD; arg_q <= SLOT_A;   end
					CMD_B:    begin func_q <= FN_LOD; arg_q <= SLOT_B;   end
					CMD_C:    begin func_q <= FN_LOD; arg_q <= SLOT_C;   end
					CMD_ADD:  begin func_q <= FN_OPR; arg_q <= ARG_ADD;  end
					CMD_SUB:  begin func_q <= FN_OPR; arg_q <= ARG_SUB;  end
					CMD_MUL:  begin func_q <= FN_OPR; arg_q <= ARG_MUL;  end
					CMD_DIV:  begin func_q <= FN_OPR; arg_q <= ARG_DIV;  end
					default:  begin func_q <= FN_LIT; arg_q <= ARG_NONE; end
				endcase
			end
			S_EXEC: begin
				unique case (cmd_q)
					CMD_MUL: res_q <= prod;
					CMD_DIV: begin
						if (y_q == '0) begin
							res_q  <= '0;
							div0_q <= 1'b1;
						end else begin
							quo_q  <= x_abs;
							dvs_q  <= y_abs;
							rem_q  <= '0;
							neg_q  <= x_val[DATA_W-1] ^ y_q[DATA_W-1];
							step_q <= '0;
						end
					end
					default: res_q <= alu_sum[DATA_W-1:0];
				endcase
			end
			S_DIV: begin
				rem_q  <= div_ge ? alu_sum[DATA_W-1:0] : alu_a[DATA_W-1:0];
				quo_q  <= {quo_q[DATA_W-2:0], div_ge};
				step_q <= STEP_W'(step_q + STEP_W'(1));
			end
			S_DIV_FIX: begin
				res_q <= neg_q ? alu_sum[DATA_W-1:0] : quo_q;
			end
			S_WRITE: begin
				top_q <= res_q;
				priority if (under_q) begin
					status_q <= ST_UNDER;
				end else if (div0_q) begin
					status_q <= ST_DIV0;
				end else begin
					status_q <= ST_OK;
				end
			end
			default: ;
		endcase
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_top_q    <= cnt_ge1 ? top_q : EMPTY_TOP;
			out_depth_q  <= DEPTH_W'(count_q);
			out_status_q <= status_q;
			out_func_q   <= func_q;
			out_arg_q    <= arg_q;
		end
	end

	assign res.valid          = out_valid_q;
	assign res.top_value      = out_top_q;
	assign res.depth          = out_depth_q;
	assign res.status         = out_status_q;
	assign res.pcode_function = out_func_q;
	assign res.pcode_argument = out_arg_q;

	// Assertions
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(STACK_DEPTH))
		else $error("stack depth beyond capacity");

	a_write_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WRITE) |=> (count_q != '0))
		else $error("stack empty after operator result");

	a_div0_opr: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.status == ST_DIV0)
			|-> (res.pcode_function == FN_OPR && res.pcode_argument == ARG_DIV))
		else $error("divide by zero reported for a non-divide token");

	a_over_push: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.status == ST_OVER) |-> (res.pcode_function != FN_OPR))
		else $error("overflow reported for an operator");

	a_load_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> res.valid)
		else $error("result load did not raise valid");

endmodule
